### rtl/pdfd_pkg.sv
// ----------------------------------------------------------------------------
// pdfd_pkg: shared types and constants of the pulse-distance frame decoder
// Holds the command and result records, codes and register reset values.
// ----------------------------------------------------------------------------
package pdfd_pkg;

  localparam int unsigned IvW    = 24;
  localparam int unsigned CntW   = 7;
  localparam int unsigned FrameW = 64;
  localparam int unsigned ErrW   = 32;
  localparam int unsigned IdxW   = 3;

  // register indexes
  localparam logic [IdxW-1:0] RegGlitchLimit   = 3'd0;
  localparam logic [IdxW-1:0] RegBitThreshold  = 3'd1;
  localparam logic [IdxW-1:0] RegStartThresh   = 3'd2;
  localparam logic [IdxW-1:0] RegFrameGap      = 3'd3;
  localparam logic [IdxW-1:0] RegFrameTimeout  = 3'd4;

  // register reset values
  localparam logic [IvW-1:0] GlitchLimitRst    = 24'd200;
  localparam logic [IvW-1:0] BitThresholdRst   = 24'd1000;
  localparam logic [IvW-1:0] StartThresholdRst = 24'd2700;
  localparam logic [IvW-1:0] FrameGapRst       = 24'd3500;
  localparam logic [IvW-1:0] FrameTimeoutRst   = 24'd10000;

  // input operation codes
  localparam logic OpEdge = 1'b0;
  localparam logic OpIdle = 1'b1;

  // result kinds
  typedef enum logic [2:0] {
    KIND_GLITCH   = 3'd0,
    KIND_GAP      = 3'd1,
    KIND_START    = 3'd2,
    KIND_BIT_ZERO = 3'd3,
    KIND_BIT_ONE  = 3'd4,
    KIND_OVERFLOW = 3'd5,
    KIND_IDLE_NOP = 3'd6,
    KIND_IDLE_JUD = 3'd7
  } kind_e;

  // classes decided by the front end
  typedef enum logic [2:0] {
    CLS_GLITCH    = 3'd0,
    CLS_GAP       = 3'd1,
    CLS_START     = 3'd2,
    CLS_DATA      = 3'd3,
    CLS_IDLE_QUIET = 3'd4,
    CLS_IDLE_EXPIRED = 3'd5
  } cls_e;

  typedef struct packed {
    cls_e cls;
    logic bit_one;
  } cmd_t;

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] index;
    logic [IvW-1:0]  data;
  } cfg_wr_t;

  typedef struct packed {
    kind_e             kind;
    logic [CntW-1:0]   bit_count;
    logic              frame_complete;
    logic              frame_changed;
    logic              frame_discarded;
    logic [FrameW-1:0] frame_bits;
    logic [ErrW-1:0]   error_count;
  } res_t;

endpackage

### rtl/pdfd_fifo.sv
// ----------------------------------------------------------------------------
// pdfd_fifo: small register queue
// Push/pop queue of records, used between front and back and at the output.
// ----------------------------------------------------------------------------
module pdfd_fifo #(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     wdata_i,
  output logic full_o,
  input  logic pop_i,
  output T     rdata_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  T                mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

### rtl/pdfd_front.sv
// ----------------------------------------------------------------------------
// pdfd_front: configuration registers and item classifier
// Compares each interval against the thresholds in test order.
// ----------------------------------------------------------------------------
module pdfd_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  pdfd_pkg::cfg_wr_t       cfg_i,
  input  logic                    operation_i,
  input  logic [pdfd_pkg::IvW-1:0] interval_us_i,
  output pdfd_pkg::cmd_t          cmd_o
);

  logic [pdfd_pkg::IvW-1:0] glitch_q, bit_thr_q, start_thr_q, gap_q, timeout_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glitch_q    <= pdfd_pkg::GlitchLimitRst;
      bit_thr_q   <= pdfd_pkg::BitThresholdRst;
      start_thr_q <= pdfd_pkg::StartThresholdRst;
      gap_q       <= pdfd_pkg::FrameGapRst;
      timeout_q   <= pdfd_pkg::FrameTimeoutRst;
    end else if (cfg_i.we) begin
      case (cfg_i.index)
        pdfd_pkg::RegGlitchLimit:  glitch_q    <= cfg_i.data;
        pdfd_pkg::RegBitThreshold: bit_thr_q   <= cfg_i.data;
        pdfd_pkg::RegStartThresh:  start_thr_q <= cfg_i.data;
        pdfd_pkg::RegFrameGap:     gap_q       <= cfg_i.data;
        pdfd_pkg::RegFrameTimeout: timeout_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // classification, first matching test wins
  always_comb begin
    cmd_o.bit_one = (interval_us_i < bit_thr_q);
    if (operation_i == pdfd_pkg::OpIdle) begin
      cmd_o.cls = (interval_us_i > timeout_q) ? pdfd_pkg::CLS_IDLE_EXPIRED
                                              : pdfd_pkg::CLS_IDLE_QUIET;
    end else if (interval_us_i < glitch_q) begin
      cmd_o.cls = pdfd_pkg::CLS_GLITCH;
    end else if (interval_us_i > gap_q) begin
      cmd_o.cls = pdfd_pkg::CLS_GAP;
    end else if (interval_us_i >= start_thr_q) begin
      cmd_o.cls = pdfd_pkg::CLS_START;
    end else begin
      cmd_o.cls = pdfd_pkg::CLS_DATA;
    end
  end

endmodule

### rtl/pdfd_back.sv
// ----------------------------------------------------------------------------
// pdfd_back: frame state and result builder
// Applies one classified command per cycle, unless stalled, to the frame state
// ----------------------------------------------------------------------------
module pdfd_back #(
  parameter int unsigned FRAME_BITS = 41
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pdfd_pkg::cmd_t cmd_i,
  input  logic           cmd_empty_i,
  output logic           cmd_pop_o,
  input  logic           res_full_i,
  output logic           res_push_o,
  output pdfd_pkg::res_t res_o
);

  localparam logic [pdfd_pkg::CntW-1:0] FrameCnt = pdfd_pkg::CntW'(FRAME_BITS);

  logic [pdfd_pkg::FrameW-1:0] staged_q, staged_d;
  logic [pdfd_pkg::FrameW-1:0] held_q, held_d;
  logic [pdfd_pkg::CntW-1:0]   count_q, count_d;
  logic                        error_q, error_d;
  logic [pdfd_pkg::ErrW-1:0]   overflow_q, overflow_d;
  logic                        fire;

  assign fire       = !cmd_empty_i && !res_full_i;
  assign cmd_pop_o  = fire;
  assign res_push_o = fire;

  // state update and result for the command at the head
  always_comb begin
    staged_d   = staged_q;
    held_d     = held_q;
    count_d    = count_q;
    error_d    = error_q;
    overflow_d = overflow_q;
    res_o.kind            = pdfd_pkg::KIND_GLITCH;
    res_o.frame_complete  = 1'b0;
    res_o.frame_changed   = 1'b0;
    res_o.frame_discarded = 1'b0;
    case (cmd_i.cls)
      pdfd_pkg::CLS_GLITCH: begin
        res_o.kind = pdfd_pkg::KIND_GLITCH;
      end
      pdfd_pkg::CLS_GAP, pdfd_pkg::CLS_START: begin
        res_o.kind = (cmd_i.cls == pdfd_pkg::CLS_GAP) ? pdfd_pkg::KIND_GAP
                                                       : pdfd_pkg::KIND_START;
        staged_d = '0;
        count_d  = '0;
        error_d  = 1'b0;
      end
      pdfd_pkg::CLS_DATA: begin
        if (count_q >= FrameCnt) begin
          // bit after a full frame
          res_o.kind = pdfd_pkg::KIND_OVERFLOW;
          error_d    = 1'b1;
          if (!(&overflow_q)) begin
            overflow_d = overflow_q + 1'b1;
          end
        end else begin
          if (cmd_i.bit_one) begin
            res_o.kind = pdfd_pkg::KIND_BIT_ONE;
            staged_d   = staged_q | (pdfd_pkg::FrameW'(1) << count_q[5:0]);
          end else begin
            res_o.kind = pdfd_pkg::KIND_BIT_ZERO;
          end
          count_d              = count_q + 1'b1;
          res_o.frame_complete = (count_d == FrameCnt);
        end
      end
      pdfd_pkg::CLS_IDLE_EXPIRED: begin
        if (count_q != '0) begin
          res_o.kind = pdfd_pkg::KIND_IDLE_JUD;
          if (count_q == FrameCnt && !error_q) begin
            if (staged_q != held_q) begin
              held_d              = staged_q;
              res_o.frame_changed = 1'b1;
            end
          end else begin
            res_o.frame_discarded = 1'b1;
          end
          count_d = '0;
        end else begin
          res_o.kind = pdfd_pkg::KIND_IDLE_NOP;
        end
      end
      default: begin
        res_o.kind = pdfd_pkg::KIND_IDLE_NOP;
      end
    endcase
    res_o.bit_count   = count_d;
    res_o.frame_bits  = held_d;
    res_o.error_count = overflow_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      staged_q   <= '0;
      held_q     <= '0;
      count_q    <= '0;
      error_q    <= 1'b0;
      overflow_q <= '0;
    end else if (fire) begin
      staged_q   <= staged_d;
      held_q     <= held_d;
      count_q    <= count_d;
      error_q    <= error_d;
      overflow_q <= overflow_d;
    end
  end

endmodule

### rtl/pulse_distance_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// pulse_distance_frame_decoder_top: pulse-distance frame decoder
// Usage:
//   input queue: drive operation_i/interval_us_i and raise push; the item
//   transfers at a clock edge with push high and full low
//   result queue: while empty is low the oldest result is on the result
//   ports; it transfers at a clock edge with pop high and empty low
//   configuration: cfg_we_i with cfg_index_i/cfg_data_i writes one register
//   at a clock edge; write only while no item is in flight
// Path: a transferred item is held in the command queue; the back end takes
//   it while the result queue is not full and writes its result into the result
//   queue, from whose head it is on the result ports and can transfer
// Throughput: one item per cycle while the result queue does not fill, set by
//   the frame state update in the back end; both queues hold two entries
// Reset: all registers return to their defaults, the frame state clears and
//   both queues empty
// Stall: when pop stays low the result queue fills, the back end holds, the
//   command queue fills and full rises; nothing is dropped
// ----------------------------------------------------------------------------
module pulse_distance_frame_decoder_top #(
  parameter int unsigned FRAME_BITS = 41
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pdfd_pkg::IdxW-1:0]     cfg_index_i,
  input  logic [pdfd_pkg::IvW-1:0]      cfg_data_i,
  input  logic                          push,
  output logic                          full,
  input  logic                          operation_i,
  input  logic [pdfd_pkg::IvW-1:0]      interval_us_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [2:0]                    kind_o,
  output logic [pdfd_pkg::CntW-1:0]     bit_count_o,
  output logic                          frame_complete_o,
  output logic                          frame_changed_o,
  output logic                          frame_discarded_o,
  output logic [pdfd_pkg::FrameW-1:0]   frame_bits_o,
  output logic [pdfd_pkg::ErrW-1:0]     error_count_o
);

  pdfd_pkg::cfg_wr_t cfg;
  pdfd_pkg::cmd_t    front_cmd, head_cmd;
  pdfd_pkg::res_t    back_res, out_res;
  logic              cmd_empty, cmd_pop, res_full, res_push;

  assign cfg.we    = cfg_we_i;
  assign cfg.index = cfg_index_i;
  assign cfg.data  = cfg_data_i;

  // front end: registers and classification
  pdfd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .operation_i   (operation_i),
    .interval_us_i (interval_us_i),
    .cmd_o         (front_cmd)
  );

  // command queue between front and back
  pdfd_fifo #(
    .T     (pdfd_pkg::cmd_t),
    .DEPTH (2)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_cmd),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .rdata_o (head_cmd),
    .empty_o (cmd_empty)
  );

  // back end: frame state
  pdfd_back #(
    .FRAME_BITS (FRAME_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (head_cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (back_res)
  );

  // result queue
  pdfd_fifo #(
    .T     (pdfd_pkg::res_t),
    .DEPTH (2)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (back_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (out_res),
    .empty_o (empty)
  );

  assign kind_o            = out_res.kind;
  assign bit_count_o       = out_res.bit_count;
  assign frame_complete_o  = out_res.frame_complete;
  assign frame_changed_o   = out_res.frame_changed;
  assign frame_discarded_o = out_res.frame_discarded;
  assign frame_bits_o      = out_res.frame_bits;
  assign error_count_o     = out_res.error_count;

endmodule
